// ===== rtl/y2r_pkg.sv =====
// types, constants and arithmetic helpers for the yuv 4:2:0 quad to rgb565 converter
// no dependencies; imported by yuv420_quad_to_rgb565
package y2r_pkg;

	localparam int QuadPixels = 4;

	// widths of the intermediate values
	localparam int TermW = 17;	// chroma term, signed, magnitude below 2^16
	localparam int AccW  = 18;	// per-channel sum before the shift, signed

	// conversion coefficients, 8 fractional bits
	localparam logic signed [TermW-1:0] CoefRv = 17'sd359;
	localparam logic signed [TermW-1:0] CoefGu = 17'sd88;
	localparam logic signed [TermW-1:0] CoefGv = 17'sd183;
	localparam logic signed [TermW-1:0] CoefBu = 17'sd454;
	localparam logic signed [8:0]       ChromaOffset = 9'sd128;
	localparam logic signed [AccW-1:0]  RoundHalf = 18'sd128;

	typedef logic signed [TermW-1:0] term_t;
	typedef logic signed [AccW-1:0]  acc_t;

	// input transaction: shared chroma pair and four luma bytes
	typedef struct packed {
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
	} quad_in_t;

	// output transaction: four packed {b[7:3], g[7:2], r[7:3]} words
	typedef struct packed {
		logic [15:0] pixel_top_left;
		logic [15:0] pixel_top_right;
		logic [15:0] pixel_bottom_left;
		logic [15:0] pixel_bottom_right;
	} quad_out_t;

	// per-quad chroma contributions
	typedef struct packed {
		term_t r_term;
		term_t g_term;
		term_t b_term;
	} chroma_terms_t;

	// per-pixel channel sums
	typedef struct packed {
		acc_t r_acc;
		acc_t g_acc;
		acc_t b_acc;
	} pixel_acc_t;

	// remove the chroma offset and widen to term width
	function automatic term_t chroma_delta(input logic [7:0] c);
		logic signed [8:0] d;
		d = $signed({1'b0, c}) - ChromaOffset;
		return TermW'(d);
	endfunction

	function automatic chroma_terms_t chroma_terms(input logic [7:0] u, input logic [7:0] v);
		term_t du;
		term_t dv;
		chroma_terms_t t;
		du = chroma_delta(u);
		dv = chroma_delta(v);
		t.r_term = dv * CoefRv;
		t.g_term = -((du * CoefGu) + (dv * CoefGv));
		t.b_term = du * CoefBu;
		return t;
	endfunction

	// 256*y + term + 128
	function automatic acc_t channel_sum(input logic [7:0] y, input term_t term);
		acc_t base;
		base = $signed({2'b00, y, 8'h00});
		return base + AccW'(term) + RoundHalf;
	endfunction

	// floor shift by 8 and clamp to 0..255
	function automatic logic [7:0] saturate(input acc_t acc);
		logic [7:0] q;
		if (acc[AccW-1]) begin
			q = 8'h00;
		end else if (acc[16]) begin
			q = 8'hff;
		end else begin
			q = acc[15:8];
		end
		return q;
	endfunction

	function automatic logic [15:0] pack565(input pixel_acc_t a);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = saturate(a.r_acc);
		g = saturate(a.g_acc);
		b = saturate(a.b_acc);
		return {b[7:3], g[7:2], r[7:3]};
	endfunction

endpackage

// ===== rtl/yuv420_quad_to_rgb565.sv =====
// yuv 4:2:0 quad (one chroma pair, four luma) to four rgb565 pixels
// one quad per cycle throughput while rgb_stall is low, set by the three-stage
// pipeline (chroma multiply, sum, clamp/pack)
// a stalled stage holds its data; empty stages still fill while the output waits
// reset (arst_n, asynchronous, active low) clears the stage valid bits only
// depends on y2r_pkg
module yuv420_quad_to_rgb565 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               yuv_valid,
	output logic               yuv_stall,
	input  y2r_pkg::quad_in_t  yuv,
	output logic               rgb_valid,
	input  logic               rgb_stall,
	output y2r_pkg::quad_out_t rgb
);
	import y2r_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	chroma_terms_t       terms_s1;
	logic [7:0]          luma_s1 [QuadPixels];
	pixel_acc_t          acc_s2 [QuadPixels];
	quad_out_t           rgb_s3;

	logic [7:0]          luma_in [QuadPixels];
	logic [15:0]         word_s2 [QuadPixels];

	// stage advance: a stage loads when empty or when its contents move on
	assign adv_s3    = !valid_s3 || !rgb_stall;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign yuv_stall = !adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= yuv_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// luma in pixel order
	assign luma_in[0] = yuv.luma_top_left;
	assign luma_in[1] = yuv.luma_top_right;
	assign luma_in[2] = yuv.luma_bottom_left;
	assign luma_in[3] = yuv.luma_bottom_right;

	// stage 1: chroma terms, shared by the four pixels
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			terms_s1 <= chroma_terms(yuv.chroma_u, yuv.chroma_v);
			for (int i = 0; i < QuadPixels; i++) begin
				luma_s1[i] <= luma_in[i];
			end
		end
	end

	// stage 2: per-pixel channel sums
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int i = 0; i < QuadPixels; i++) begin
				acc_s2[i].r_acc <= channel_sum(luma_s1[i], terms_s1.r_term);
				acc_s2[i].g_acc <= channel_sum(luma_s1[i], terms_s1.g_term);
				acc_s2[i].b_acc <= channel_sum(luma_s1[i], terms_s1.b_term);
			end
		end
	end

	// clamp and pack each pixel
	always_comb begin
		for (int i = 0; i < QuadPixels; i++) begin
			word_s2[i] = pack565(acc_s2[i]);
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			rgb_s3.pixel_top_left     <= word_s2[0];
			rgb_s3.pixel_top_right    <= word_s2[1];
			rgb_s3.pixel_bottom_left  <= word_s2[2];
			rgb_s3.pixel_bottom_right <= word_s2[3];
		end
	end

	assign rgb_valid = valid_s3;
	assign rgb       = rgb_s3;

endmodule
